/* rtl/core/owm_pkg.sv */
`default_nettype none
package owm_pkg;

   localparam int CFG_W          = 10;
   localparam int NUM_CFG        = 8;
   localparam int CFG_IDX_W      = 3;
   localparam int BYTE_W         = 8;
   localparam int BIT_IDX_W      = $clog2(BYTE_W);
   localparam int TIMER_BITS_DEF = 10;
   localparam int QUEUE_DEPTH    = 2;
   localparam int REQ_TDATA_W    = 16;
   localparam int REQ_TUSER_W    = 3;
   localparam int RSP_TDATA_W    = 16;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd7;

   typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_regs_type;

   localparam cfg_regs_type CFG_INIT = {
      10'd0, 10'd60, 10'd2, 10'd50, 10'd1, 10'd400, 10'd80, 10'd480
   };

   // bus actions
   localparam logic [1:0] ACT_RESET = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // command kinds after classification
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RESET = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BAD   = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] wbyte;
      logic              bus;
   } item_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic              presence;
      logic [BYTE_W-1:0] read_byte;
      logic              cmd_rejected;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/core/owm_front.sv */
`default_nettype none
module owm_front (
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [owm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [owm_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  wire logic                               q_ready,
   output logic                                    q_push,
   output owm_pkg::item_type                       q_item
);

   logic       cmd_valid;
   logic [1:0] action;

   assign cmd_valid  = req_tuser[0];
   assign action     = req_tuser[2:1];
   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      q_item.wbyte = req_tdata[owm_pkg::BYTE_W-1:0];
      q_item.bus   = req_tdata[owm_pkg::BYTE_W];
      q_item.kind  = owm_pkg::KIND_NONE;
      if (cmd_valid) begin
         case (action)
            owm_pkg::ACT_RESET: q_item.kind = owm_pkg::KIND_RESET;
            owm_pkg::ACT_WRITE: q_item.kind = owm_pkg::KIND_WRITE;
            owm_pkg::ACT_READ:  q_item.kind = owm_pkg::KIND_READ;
            default:            q_item.kind = owm_pkg::KIND_BAD;
         endcase
      end
   end

endmodule
`default_nettype wire

/* rtl/core/owm_queue.sv */
`default_nettype none
module owm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire owm_pkg::item_type push_item,
   output logic                   push_ready,
   input  wire logic              pop,
   output logic                   pop_valid,
   output owm_pkg::item_type      pop_item
);

   localparam int DEPTH = owm_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   owm_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/owm_back.sv */
`default_nettype none
module owm_back #(
   parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [owm_pkg::CFG_IDX_W-1:0]     csr_addr,
   input  wire logic [owm_pkg::CFG_W-1:0]         csr_wdata,
   input  wire logic                              q_valid,
   input  wire owm_pkg::item_type                 q_item,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output owm_pkg::rsp_type                       rsp_data
);

   localparam int CFG_W = owm_pkg::CFG_W;
   localparam int BW    = owm_pkg::BYTE_W;
   localparam int IW    = owm_pkg::BIT_IDX_W;
   localparam int LW    = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
   localparam logic [LW-1:0] LEN_MAX = LW'((64'd1 << TIMER_BITS) - 64'd1);
   localparam logic [IW-1:0] BIT_LAST = IW'(BW - 1);

   localparam logic [3:0] PH_IDLE       = 4'd0;
   localparam logic [3:0] PH_RST_LOW    = 4'd1;
   localparam logic [3:0] PH_RST_WAIT   = 4'd2;
   localparam logic [3:0] PH_RST_SAMPLE = 4'd3;
   localparam logic [3:0] PH_RST_TAIL   = 4'd4;
   localparam logic [3:0] PH_W1_LOW     = 4'd5;
   localparam logic [3:0] PH_W1_REL     = 4'd6;
   localparam logic [3:0] PH_W0_LOW     = 4'd7;
   localparam logic [3:0] PH_W0_REC     = 4'd8;
   localparam logic [3:0] PH_RD_LOW     = 4'd9;
   localparam logic [3:0] PH_RD_SAMPLE  = 4'd10;
   localparam logic [3:0] PH_RD_TAIL    = 4'd11;

   owm_pkg::cfg_regs_type  cfg_ff, cfg_in;
   logic [3:0]             phase_ff, phase_in;
   logic [TIMER_BITS-1:0]  tick_ff, tick_in;
   logic [IW-1:0]          bit_ff, bit_in;
   logic [BW-1:0]          shift_ff, shift_in;
   logic [1:0]             op_ff, op_in;
   logic                   pres_ff, pres_in;
   logic [BW-1:0]          rdbyte_ff, rdbyte_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   owm_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   step;
   logic                   idle, start, rejected, active;
   logic [3:0]             cur_phase, p1, eob_phase, nxt_phase;
   logic [TIMER_BITS-1:0]  cur_tick, tick_next;
   logic [IW-1:0]          cur_bit;
   logic [BW-1:0]          cur_shift, shift_s, eob_shift;
   logic [1:0]             cur_op;
   logic                   pres_s;
   logic [CFG_W-1:0]       len_sel;
   logic                   len_min1;
   logic [LW-1:0]          len_raw, len_clip;
   logic                   phase_end, bit_end_phase, skip_to_eob, skip_rst, eob, last_bit;
   logic                   drive;

   assign step  = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop = step;

   always_comb begin
      cfg_in = cfg_ff;
      for (int i = 0; i < owm_pkg::NUM_CFG; i++) begin
         if (csr_we && (csr_addr == owm_pkg::CFG_IDX_W'(i))) begin
            cfg_in[i] = csr_wdata;
         end
      end
   end

   // front end of the tick: command start or rejection
   always_comb begin
      idle     = (phase_ff == PH_IDLE);
      start    = idle && ((q_item.kind == owm_pkg::KIND_RESET) ||
                          (q_item.kind == owm_pkg::KIND_WRITE) ||
                          (q_item.kind == owm_pkg::KIND_READ));
      rejected = (q_item.kind != owm_pkg::KIND_NONE) &&
                 (!idle || (q_item.kind == owm_pkg::KIND_BAD));
      cur_phase = phase_ff;
      cur_tick  = tick_ff;
      cur_bit   = bit_ff;
      cur_shift = shift_ff;
      cur_op    = op_ff;
      if (start) begin
         cur_tick = '0;
         cur_bit  = '0;
         case (q_item.kind)
            owm_pkg::KIND_RESET: begin
               cur_op    = owm_pkg::ACT_RESET;
               cur_phase = PH_RST_LOW;
            end
            owm_pkg::KIND_WRITE: begin
               cur_op    = owm_pkg::ACT_WRITE;
               cur_shift = q_item.wbyte;
               cur_phase = q_item.wbyte[0] ? PH_W1_LOW : PH_W0_LOW;
            end
            owm_pkg::KIND_READ: begin
               cur_op    = owm_pkg::ACT_READ;
               cur_shift = '0;
               cur_phase = PH_RD_LOW;
            end
            default: begin
               cur_phase = phase_ff;
            end
         endcase
      end
   end

   // phase length, clipped to the timer range
   always_comb begin
      len_min1 = 1'b1;
      case (cur_phase)
         PH_RST_LOW:  len_sel = cfg_ff[owm_pkg::REG_RESET_LOW];
         PH_RST_WAIT: len_sel = cfg_ff[owm_pkg::REG_PRESENCE_WAIT];
         PH_W1_LOW:   len_sel = cfg_ff[owm_pkg::REG_WRITE_ONE_LOW];
         PH_W1_REL:   len_sel = cfg_ff[owm_pkg::REG_SLOT];
         PH_W0_LOW:   len_sel = cfg_ff[owm_pkg::REG_SLOT];
         PH_RD_LOW:   len_sel = cfg_ff[owm_pkg::REG_READ_LOW];
         PH_RST_TAIL: begin
            len_sel  = cfg_ff[owm_pkg::REG_RESET_TAIL];
            len_min1 = 1'b0;
         end
         PH_W0_REC: begin
            len_sel  = cfg_ff[owm_pkg::REG_RECOVERY];
            len_min1 = 1'b0;
         end
         PH_RD_TAIL: begin
            len_sel  = cfg_ff[owm_pkg::REG_READ_TAIL];
            len_min1 = 1'b0;
         end
         default: len_sel = CFG_W'(1);
      endcase
      len_raw = LW'(len_sel);
      if (len_min1 && (len_sel == '0)) begin
         len_raw = LW'(1);
      end
      len_clip = (len_raw > LEN_MAX) ? LEN_MAX : len_raw;
   end

   // back end of the tick: line action, sampling and phase advance
   always_comb begin
      active = (cur_phase != PH_IDLE);
      drive  = (cur_phase == PH_RST_LOW) || (cur_phase == PH_W1_LOW) ||
               (cur_phase == PH_W0_LOW) || (cur_phase == PH_RD_LOW);
      shift_s = cur_shift;
      if (cur_phase == PH_RD_SAMPLE) begin
         shift_s = {q_item.bus, cur_shift[BW-1:1]};
      end
      pres_s = pres_ff;
      if (cur_phase == PH_RST_SAMPLE) begin
         pres_s = !q_item.bus;
      end
      tick_next = cur_tick + TIMER_BITS'(1);
      phase_end = active && (LW'(tick_next) >= len_clip);

      case (cur_phase)
         PH_RST_LOW:    p1 = PH_RST_WAIT;
         PH_RST_WAIT:   p1 = PH_RST_SAMPLE;
         PH_RST_SAMPLE: p1 = PH_RST_TAIL;
         PH_W1_LOW:     p1 = PH_W1_REL;
         PH_W0_LOW:     p1 = PH_W0_REC;
         PH_RD_LOW:     p1 = PH_RD_SAMPLE;
         PH_RD_SAMPLE:  p1 = PH_RD_TAIL;
         default:       p1 = PH_IDLE;
      endcase

      // a tail of zero length is skipped straight to what follows it
      bit_end_phase = (cur_phase == PH_W1_REL) || (cur_phase == PH_W0_REC) ||
                      (cur_phase == PH_RD_TAIL);
      skip_to_eob   = ((p1 == PH_W0_REC) && (cfg_ff[owm_pkg::REG_RECOVERY] == '0)) ||
                      ((p1 == PH_RD_TAIL) && (cfg_ff[owm_pkg::REG_READ_TAIL] == '0));
      skip_rst      = (p1 == PH_RST_TAIL) && (cfg_ff[owm_pkg::REG_RESET_TAIL] == '0);
      eob           = bit_end_phase || skip_to_eob;

      last_bit  = (cur_bit == BIT_LAST);
      eob_shift = (cur_op == owm_pkg::ACT_WRITE) ? (shift_s >> 1) : shift_s;
      if (last_bit) begin
         eob_phase = PH_IDLE;
      end else if (cur_op == owm_pkg::ACT_WRITE) begin
         eob_phase = eob_shift[0] ? PH_W1_LOW : PH_W0_LOW;
      end else begin
         eob_phase = PH_RD_LOW;
      end

      nxt_phase = cur_phase;
      if (phase_end) begin
         if (eob) begin
            nxt_phase = eob_phase;
         end else if (skip_rst) begin
            nxt_phase = PH_IDLE;
         end else begin
            nxt_phase = p1;
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      op_in     = op_ff;
      pres_in   = pres_ff;
      rdbyte_in = rdbyte_ff;
      rsp_in    = rsp_ff;
      if (step) begin
         phase_in = nxt_phase;
         tick_in  = phase_end ? '0 : (active ? tick_next : cur_tick);
         bit_in   = cur_bit;
         shift_in = shift_s;
         op_in    = cur_op;
         pres_in  = pres_s;
         if (phase_end && eob) begin
            if (last_bit) begin
               if (cur_op == owm_pkg::ACT_READ) begin
                  rdbyte_in = shift_s;
               end
            end else begin
               bit_in   = cur_bit + 1'b1;
               shift_in = eob_shift;
            end
         end
         rsp_in.drive_low    = active && drive;
         rsp_in.busy_res     = active;
         rsp_in.done_res     = phase_end && (nxt_phase == PH_IDLE);
         rsp_in.presence     = pres_in;
         rsp_in.read_byte    = rdbyte_in;
         rsp_in.cmd_rejected = rejected;
      end
      rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= owm_pkg::CFG_INIT;
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         op_ff        <= owm_pkg::ACT_RESET;
         pres_ff      <= 1'b0;
         rdbyte_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         op_ff        <= op_in;
         pres_ff      <= pres_in;
         rdbyte_ff    <= rdbyte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> rsp_ff.busy_res)
      else $error("done beat without busy");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.drive_low |-> rsp_ff.busy_res)
      else $error("line driven while not busy");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> tick_ff == '0)
      else $error("timer running while idle");

   a_step_out: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("consumed tick produced no beat");

   a_hold_phase: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("sequencer moved without a tick");
`endif

endmodule
`default_nettype wire

/* rtl/core/one_wire_bus_master_top.sv */
// 1-Wire bus master. Each req beat is one microsecond tick of the bus timebase and
// carries the sampled line level plus an optional command (reset with presence
// detect, write byte, read byte); each tick returns exactly one rsp beat with the
// line drive, busy, done (tlast), presence, last read byte and a reject flag.
// Commands offered while busy, or with an unknown action, are rejected. The block
// sustains one beat per clock while neither side stalls: a classifier feeds a
// two-entry queue, and the sequencer consumes one tick per cycle into an output
// register; either side may stall freely. Phase timings come from eight 10-bit
// csr registers, written only while idle, a user rule the block does not enforce.
`default_nettype none
module one_wire_bus_master_top #(
   parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // write_byte[7:0], bus_level[8], zero pad
   input  wire logic [owm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd_valid[0], action[2:1]
   input  wire logic [owm_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // drive_low[0], busy_res[1], presence[2], read_byte[10:3], cmd_rejected[11], pad
   output logic [owm_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  wire logic                            csr_we,
   input  wire logic [owm_pkg::CFG_IDX_W-1:0]   csr_addr,
   input  wire logic [owm_pkg::CFG_W-1:0]       csr_wdata
);

   logic              q_ready, q_push, q_valid, q_pop;
   owm_pkg::item_type push_item, pop_item;
   owm_pkg::rsp_type  rsp_data;

   owm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   owm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (pop_item)
   );

   owm_back #(
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tlast = rsp_data.done_res;
   assign rsp_tdata = {4'b0000, rsp_data.cmd_rejected, rsp_data.read_byte,
                       rsp_data.presence, rsp_data.busy_res, rsp_data.drive_low};

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
module tb_top;

   localparam int TIMER_W      = owm_pkg::TIMER_BITS_DEF;
   localparam int CFG_W        = owm_pkg::CFG_W;
   localparam int RANDOM_TICKS = 850;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   typedef enum logic [3:0] {
      BUS_IDLE, RST_PULSE, RST_WAIT, RST_SAMPLE, RST_TAIL,
      ONE_LOW, ONE_REL, ZERO_LOW, ZERO_REC, RD_PULSE, RD_SAMPLE, RD_TAIL
   } seq_phase_type;

   // line level fed in while a command runs out after a directed row
   typedef enum {TAIL_NONE, TAIL_LOW, TAIL_HIGH, TAIL_ANY} tail_mode_type;

   typedef struct {
      bit               v;
      logic [1:0]       act;
      logic [7:0]       wb;
      bit               bus;
      tail_mode_type    tail;
      bit               fixed;
      owm_pkg::rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [owm_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [owm_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [owm_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [owm_pkg::CFG_IDX_W-1:0] csr_addr = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   one_wire_bus_master_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("[one_wire_bus_master_top] ERROR");
      $finish;
   end

   // bus sequencer mirror
   logic [CFG_W-1:0]   timing [owm_pkg::NUM_CFG];
   seq_phase_type      phase_q;
   logic [TIMER_W-1:0] ticks_q;
   logic [2:0]         bit_q;
   logic [7:0]         shreg_q;
   logic [1:0]         op_q;
   logic               pres_q;
   logic [7:0]         rd_byte_q;
   bit                 done_q;

   owm_pkg::rsp_type predicted_ticks [$];
   stim_row_type     dir_rows [$];

   int  mismatch_count = 0;
   int  rsp_seen = 0;
   int  random_ticks = 0;
   int  n_settings = 0;
   int  n_resets = 0;
   int  n_writes = 0;
   int  n_reads = 0;
   int  n_refused = 0;
   bit  sender_gaps = 1'b1;
   bit  hold_pending = 1'b0;
   int  ready_run = 0;

   function automatic logic [TIMER_W-1:0] span(input seq_phase_type p);
      int unsigned lim;
      int unsigned v;
      bit          min1;
      lim  = (1 << TIMER_W) - 1;
      min1 = 1'b1;
      case (p)
         RST_PULSE: v = 32'(timing[owm_pkg::REG_RESET_LOW]);
         RST_WAIT:  v = 32'(timing[owm_pkg::REG_PRESENCE_WAIT]);
         RST_TAIL: begin
            v = 32'(timing[owm_pkg::REG_RESET_TAIL]);
            min1 = 1'b0;
         end
         ONE_LOW:   v = 32'(timing[owm_pkg::REG_WRITE_ONE_LOW]);
         ONE_REL:   v = 32'(timing[owm_pkg::REG_SLOT]);
         ZERO_LOW:  v = 32'(timing[owm_pkg::REG_SLOT]);
         ZERO_REC: begin
            v = 32'(timing[owm_pkg::REG_RECOVERY]);
            min1 = 1'b0;
         end
         RD_PULSE:  v = 32'(timing[owm_pkg::REG_READ_LOW]);
         RD_TAIL: begin
            v = 32'(timing[owm_pkg::REG_READ_TAIL]);
            min1 = 1'b0;
         end
         default:   return TIMER_W'(1);
      endcase
      if (min1 && v == 0) v = 1;
      return TIMER_W'((v > lim) ? lim : v);
   endfunction

   function automatic seq_phase_type bit_done();
      if (bit_q == 3'd7) begin
         if (op_q == owm_pkg::ACT_READ) rd_byte_q = shreg_q;
         return BUS_IDLE;
      end
      bit_q = bit_q + 3'd1;
      if (op_q == owm_pkg::ACT_WRITE) begin
         shreg_q = shreg_q >> 1;
         return shreg_q[0] ? ONE_LOW : ZERO_LOW;
      end
      return RD_PULSE;
   endfunction

   function automatic seq_phase_type next_phase(input seq_phase_type p);
      case (p)
         RST_PULSE:  return RST_WAIT;
         RST_WAIT:   return RST_SAMPLE;
         RST_SAMPLE: return RST_TAIL;
         ONE_LOW:    return ONE_REL;
         ZERO_LOW:   return ZERO_REC;
         RD_PULSE:   return RD_SAMPLE;
         RD_SAMPLE:  return RD_TAIL;
         ONE_REL, ZERO_REC, RD_TAIL: return bit_done();
         default:    return BUS_IDLE;
      endcase
   endfunction

   // zero length phases fall straight through to their successor
   function automatic void go_to(input seq_phase_type p);
      seq_phase_type q;
      q = p;
      while (q != BUS_IDLE && span(q) == '0) q = next_phase(q);
      phase_q = q;
      ticks_q = '0;
      if (q == BUS_IDLE) done_q = 1'b1;
   endfunction

   // one microsecond of the bus: returns what the block should report for it
   function automatic owm_pkg::rsp_type bus_tick(input bit v, input logic [1:0] act,
                                                 input logic [7:0] wb, input bit bus);
      owm_pkg::rsp_type r;
      r = '0;
      done_q = 1'b0;
      if (phase_q == BUS_IDLE) begin
         if (v) begin
            case (act)
               owm_pkg::ACT_RESET: begin
                  op_q = act;
                  bit_q = '0;
                  n_resets++;
                  go_to(RST_PULSE);
               end
               owm_pkg::ACT_WRITE: begin
                  op_q = act;
                  bit_q = '0;
                  shreg_q = wb;
                  n_writes++;
                  go_to(wb[0] ? ONE_LOW : ZERO_LOW);
               end
               owm_pkg::ACT_READ: begin
                  op_q = act;
                  bit_q = '0;
                  shreg_q = '0;
                  n_reads++;
                  go_to(RD_PULSE);
               end
               default: r.cmd_rejected = 1'b1;
            endcase
         end
      end else if (v) begin
         r.cmd_rejected = 1'b1;
      end
      if (r.cmd_rejected) n_refused++;
      if (phase_q != BUS_IDLE) begin
         r.busy_res  = 1'b1;
         r.drive_low = (phase_q == RST_PULSE) || (phase_q == ONE_LOW) ||
                       (phase_q == ZERO_LOW) || (phase_q == RD_PULSE);
         // a low line during the sample tick means a device answered
         if (phase_q == RST_SAMPLE) pres_q = ~bus;
         if (phase_q == RD_SAMPLE) shreg_q = {bus, shreg_q[7:1]};
         ticks_q = ticks_q + 1'b1;
         if (ticks_q >= span(phase_q)) go_to(next_phase(phase_q));
      end
      r.done_res  = done_q;
      r.presence  = pres_q;
      r.read_byte = rd_byte_q;
      return r;
   endfunction

   function automatic owm_pkg::rsp_type early_rsp(input bit drive, input bit busy,
                                                  input bit done, input bit pres,
                                                  input bit rej);
      return '{drive, busy, done, pres, 8'h00, rej};
   endfunction

   function automatic owm_pkg::cfg_regs_type random_timings();
      owm_pkg::cfg_regs_type t;
      int                    roll;
      for (int i = 0; i < owm_pkg::NUM_CFG; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) t[i] = '0;
         else if (roll < 80) t[i] = CFG_W'($urandom_range(1, 4));
         else if (roll < 95) t[i] = CFG_W'($urandom_range(5, 12));
         else t[i] = CFG_W'($urandom_range(13, 40));
      end
      return t;
   endfunction

   task automatic add_row(input bit v, input logic [1:0] act, input logic [7:0] wb,
                          input bit bus, input tail_mode_type tail, input bit fixed,
                          input owm_pkg::rsp_type want);
      stim_row_type row;
      row.v = v;
      row.act = act;
      row.wb = wb;
      row.bus = bus;
      row.tail = tail;
      row.fixed = fixed;
      row.want = want;
      dir_rows.push_back(row);
   endtask

   task automatic send_tick(input bit v, input logic [1:0] act, input logic [7:0] wb,
                            input bit bus, input bit fixed, input owm_pkg::rsp_type want);
      owm_pkg::rsp_type pred;
      int               gap;
      int               roll;
      gap = 0;
      if (sender_gaps) begin
         roll = $urandom_range(0, 99);
         if (roll >= 97) gap = $urandom_range(15, 40);
         else if (roll >= 75) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(owm_pkg::REQ_TDATA_W - 9){1'b0}}, bus, wb};
      req_tuser  <= {act, v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = bus_tick(v, act, wb, bus);
      predicted_ticks.push_back(fixed ? want : pred);
   endtask

   task automatic run_to_idle(input tail_mode_type tail);
      bit bus;
      while (phase_q != BUS_IDLE) begin
         case (tail)
            TAIL_LOW:  bus = 1'b0;
            TAIL_HIGH: bus = 1'b1;
            default:   bus = 1'($urandom_range(0, 1));
         endcase
         send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom), bus, 1'b0, '0);
      end
   endtask

   // finish the running command, drain every result, then load all timings
   task automatic retime(input owm_pkg::cfg_regs_type vals);
      run_to_idle(TAIL_ANY);
      req_tvalid <= 1'b0;
      while (predicted_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      for (int i = 0; i < owm_pkg::NUM_CFG; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= i[owm_pkg::CFG_IDX_W-1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         timing[i] = vals[i];
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic random_burst(input int n);
      bit         v;
      logic [1:0] act;
      int         roll;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         act  = 2'($urandom_range(0, 3));
         if (phase_q == BUS_IDLE) begin
            // mostly start a well formed command, now and then a bad one
            v = (roll < 85);
            if (v) begin
               act = ($urandom_range(0, 99) < 4) ? ACT_UNKNOWN :
                     2'($urandom_range(0, 2));
            end
         end else begin
            v = (roll < 10);
         end
         send_tick(v, act, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
         random_ticks++;
      end
   endtask

   initial begin
      int          stall;
      int          roll;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (ready_run > 0) begin
            ready_run--;
            rsp_tready <= 1'b1;
         end else begin
            roll  = $urandom_range(0, 99);
            stall = (roll < 25) ? 0 : (roll < 95) ? $urandom_range(1, 3) :
                    $urandom_range(20, 40);
            ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                        $urandom_range(1, 8);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   owm_pkg::rsp_type got;
   owm_pkg::rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.drive_low    = rsp_tdata[0];
         got.busy_res     = rsp_tdata[1];
         got.presence     = rsp_tdata[2];
         got.read_byte    = rsp_tdata[10:3];
         got.cmd_rejected = rsp_tdata[11];
         got.done_res     = rsp_tlast;
         if (predicted_ticks.size() == 0) begin
            if (mismatch_count < 10)
               $display("beat %0d arrived with nothing predicted", rsp_seen);
            mismatch_count++;
         end else begin
            want = predicted_ticks.pop_front();
            if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.presence !== want.presence ||
                got.read_byte !== want.read_byte ||
                got.cmd_rejected !== want.cmd_rejected) begin
               if (mismatch_count < 10) begin
                  $display("beat %0d: want drive %b busy %b done %b pres %b byte %h rej %b",
                           rsp_seen, want.drive_low, want.busy_res, want.done_res,
                           want.presence, want.read_byte, want.cmd_rejected);
                  $display("beat %0d: got  drive %b busy %b done %b pres %b byte %h rej %b",
                           rsp_seen, got.drive_low, got.busy_res, got.done_res,
                           got.presence, got.read_byte, got.cmd_rejected);
               end
               mismatch_count++;
            end
         end
         rsp_seen++;
      end
   end

   initial begin
      int phase_no;
      foreach (timing[i]) timing[i] = owm_pkg::CFG_INIT[i];
      phase_q   = BUS_IDLE;
      ticks_q   = '0;
      bit_q     = '0;
      shreg_q   = '0;
      op_q      = '0;
      pres_q    = 1'b0;
      rd_byte_q = '0;
      done_q    = 1'b0;

      // expectations typed in only for the first ticks, all timings at zero
      add_row(1'b0, owm_pkg::ACT_RESET, 8'h00, 1'b0, TAIL_NONE, 1'b1, early_rsp(0, 0, 0, 0, 0));
      add_row(1'b1, ACT_UNKNOWN, 8'h00, 1'b0, TAIL_NONE, 1'b1, early_rsp(0, 0, 0, 0, 1));
      add_row(1'b0, ACT_UNKNOWN, 8'hFF, 1'b1, TAIL_NONE, 1'b1, early_rsp(0, 0, 0, 0, 0));
      add_row(1'b1, owm_pkg::ACT_RESET, 8'h00, 1'b1, TAIL_NONE, 1'b1, early_rsp(1, 1, 0, 0, 0));
      add_row(1'b1, owm_pkg::ACT_READ, 8'hFF, 1'b0, TAIL_NONE, 1'b1, early_rsp(0, 1, 0, 0, 1));
      add_row(1'b0, owm_pkg::ACT_RESET, 8'h00, 1'b0, TAIL_NONE, 1'b1, early_rsp(0, 1, 1, 1, 0));
      add_row(1'b1, owm_pkg::ACT_RESET, 8'h00, 1'b1, TAIL_NONE, 1'b1, early_rsp(1, 1, 0, 1, 0));
      add_row(1'b0, owm_pkg::ACT_WRITE, 8'h00, 1'b1, TAIL_NONE, 1'b1, early_rsp(0, 1, 0, 1, 0));
      add_row(1'b0, owm_pkg::ACT_READ, 8'h00, 1'b1, TAIL_NONE, 1'b1, early_rsp(0, 1, 1, 0, 0));
      add_row(1'b1, owm_pkg::ACT_WRITE, 8'h00, 1'b0, TAIL_ANY, 1'b0, '0);
      add_row(1'b1, owm_pkg::ACT_WRITE, 8'hFF, 1'b1, TAIL_ANY, 1'b0, '0);
      add_row(1'b1, owm_pkg::ACT_READ, 8'h00, 1'b1, TAIL_HIGH, 1'b0, '0);
      add_row(1'b1, owm_pkg::ACT_READ, 8'hFF, 1'b0, TAIL_LOW, 1'b0, '0);
      add_row(1'b1, owm_pkg::ACT_READ, 8'h5A, 1'b0, TAIL_ANY, 1'b0, '0);
      add_row(1'b1, owm_pkg::ACT_WRITE, 8'hA5, 1'b0, TAIL_NONE, 1'b0, '0);
      add_row(1'b1, ACT_UNKNOWN, 8'h3C, 1'b1, TAIL_ANY, 1'b0, '0);
      add_row(1'b1, ACT_UNKNOWN, 8'h00, 1'b1, TAIL_NONE, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      retime('0);
      foreach (dir_rows[i]) begin
         send_tick(dir_rows[i].v, dir_rows[i].act, dir_rows[i].wb, dir_rows[i].bus,
                   dir_rows[i].fixed, dir_rows[i].want);
         if (dir_rows[i].tail != TAIL_NONE) run_to_idle(dir_rows[i].tail);
      end

      phase_no = 0;
      while (random_ticks < RANDOM_TICKS) begin
         retime(random_timings());
         if (phase_no == 0) begin
            // receiver holds off while the sender keeps pushing beats
            sender_gaps  = 1'b0;
            hold_pending = 1'b1;
            random_burst(40);
            sender_gaps  = 1'b1;
         end
         random_burst($urandom_range(60, 200));
         phase_no++;
      end

      req_tvalid <= 1'b0;
      while (predicted_ticks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d ticks checked under %0d timing settings, all zero and random",
               rsp_seen, n_settings);
      $display("%0d bus resets, %0d byte writes, %0d byte reads, %0d offers refused",
               n_resets, n_writes, n_reads, n_refused);
      if (mismatch_count == 0) begin
         $display("[one_wire_bus_master_top] OK");
      end else begin
         $display("[one_wire_bus_master_top] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/owm_pkg.sv
rtl/core/owm_front.sv
rtl/core/owm_queue.sv
rtl/core/owm_back.sv
rtl/core/one_wire_bus_master_top.sv
sim/tb_top.sv
